FILE: design/nds_pkg.sv
// Shared types, register indexes and color expansion helpers for the
// nearest-neighbor RGB565 downscaler. No dependencies.
`default_nettype none

package nds_pkg;

   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAY_MODE  = 3'd4;

   localparam int COORD_W = 11;

   typedef struct packed {
      logic [15:0] pixel;
      logic        start_of_frame;
   } req_type;

   typedef struct packed {
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         luma;
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic               last_of_frame;
   } rsp_type;

   // Selection result for the current source pixel
   typedef struct packed {
      logic               hit;
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic               last;
   } pos_type;

   typedef struct packed {
      logic s1_valid;
      logic s1_ready;
   } pipe_status_type;

   // (v*255+15)/31 == 8v + (7v+15)/31, quotient found by compares
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [7:0] n;
      logic [2:0] q;
      n = 8'(v) * 8'd7 + 8'd15;
      q = '0;
      for (int i = 1; i <= 7; i++) begin
         if (n >= 8'(31 * i)) q = q + 3'd1;
      end
      return {v, 3'b000} + 8'(q);
   endfunction

   // (v*255+31)/63 == 4v + (3v+31)/63
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [7:0] n;
      logic [1:0] q;
      n = 8'(v) * 8'd3 + 8'd31;
      q = '0;
      for (int i = 1; i <= 3; i++) begin
         if (n >= 8'(63 * i)) q = q + 2'd1;
      end
      return {v, 2'b00} + 8'(q);
   endfunction

endpackage

`default_nettype wire

FILE: design/nds_position.sv
// Source/destination position tracker with add-and-compare accumulators.
// Depends on nds_pkg.
`default_nettype none

module nds_position #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire                                logic clock,
   input  wire                                logic reset,
   input  wire                                logic advance,
   input  wire                                logic start_of_frame,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  src_width,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0] src_height,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]  dst_width,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0] dst_height,
   output nds_pkg::pos_type                     pos
);

   localparam int WS_W  = $clog2(MAX_WIDTH + 1);
   localparam int HS_W  = $clog2(MAX_HEIGHT + 1);
   localparam int WP_W  = $clog2(MAX_WIDTH);
   localparam int HP_W  = $clog2(MAX_HEIGHT);
   localparam int WA_W  = 2 * WS_W;
   localparam int HA_W  = 2 * HS_W;

   logic [WP_W-1:0] src_col_ff, src_col_in, cur_src_col;
   logic [HP_W-1:0] src_row_ff, src_row_in, cur_src_row;
   logic [WS_W-1:0] dst_col_ff, dst_col_in, cur_dst_col;
   logic [HS_W-1:0] dst_row_ff, dst_row_in, cur_dst_row;
   logic [WA_W-1:0] col_tgt_ff, col_tgt_in, cur_col_tgt;
   logic [WA_W-1:0] col_base_ff, col_base_in, cur_col_base;
   logic [HA_W-1:0] row_tgt_ff, row_tgt_in, cur_row_tgt;
   logic [HA_W-1:0] row_base_ff, row_base_in, cur_row_base;

   logic row_hit, col_hit, hit, line_end, frame_end;

   always_comb begin
      if (start_of_frame) begin
         cur_src_col  = '0;
         cur_src_row  = '0;
         cur_dst_col  = '0;
         cur_dst_row  = '0;
         cur_col_tgt  = '0;
         cur_col_base = '0;
         cur_row_tgt  = '0;
         cur_row_base = '0;
      end else begin
         cur_src_col  = src_col_ff;
         cur_src_row  = src_row_ff;
         cur_dst_col  = dst_col_ff;
         cur_dst_row  = dst_row_ff;
         cur_col_tgt  = col_tgt_ff;
         cur_col_base = col_base_ff;
         cur_row_tgt  = row_tgt_ff;
         cur_row_base = row_base_ff;
      end
   end

   assign row_hit = (cur_dst_row < dst_height) && (cur_row_base <= cur_row_tgt) &&
                    ({1'b0, cur_row_tgt} < ({1'b0, cur_row_base} + (HA_W+1)'(dst_height)));
   assign col_hit = (cur_dst_col < dst_width) && (cur_col_base <= cur_col_tgt) &&
                    ({1'b0, cur_col_tgt} < ({1'b0, cur_col_base} + (WA_W+1)'(dst_width)));
   assign hit     = row_hit && col_hit;

   assign line_end  = (WS_W'(cur_src_col) + WS_W'(1)) >= src_width;
   assign frame_end = (HS_W'(cur_src_row) + HS_W'(1)) >= src_height;

   always_comb begin
      src_col_in  = cur_src_col;
      src_row_in  = cur_src_row;
      dst_col_in  = cur_dst_col;
      dst_row_in  = cur_dst_row;
      col_tgt_in  = cur_col_tgt;
      col_base_in = cur_col_base;
      row_tgt_in  = cur_row_tgt;
      row_base_in = cur_row_base;
      if (hit) begin
         dst_col_in = cur_dst_col + WS_W'(1);
         col_tgt_in = cur_col_tgt + WA_W'(src_width);
      end
      if (line_end) begin
         src_col_in  = '0;
         col_base_in = '0;
         dst_col_in  = '0;
         col_tgt_in  = '0;
         if (frame_end) begin
            src_row_in  = '0;
            dst_row_in  = '0;
            row_tgt_in  = '0;
            row_base_in = '0;
         end else begin
            if (row_hit) begin
               dst_row_in = cur_dst_row + HS_W'(1);
               row_tgt_in = cur_row_tgt + HA_W'(src_height);
            end
            src_row_in  = cur_src_row + HP_W'(1);
            row_base_in = cur_row_base + HA_W'(dst_height);
         end
      end else begin
         src_col_in  = cur_src_col + WP_W'(1);
         col_base_in = cur_col_base + WA_W'(dst_width);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_ff  <= '0;
         src_row_ff  <= '0;
         dst_col_ff  <= '0;
         dst_row_ff  <= '0;
         col_tgt_ff  <= '0;
         col_base_ff <= '0;
         row_tgt_ff  <= '0;
         row_base_ff <= '0;
      end else if (advance) begin
         src_col_ff  <= src_col_in;
         src_row_ff  <= src_row_in;
         dst_col_ff  <= dst_col_in;
         dst_row_ff  <= dst_row_in;
         col_tgt_ff  <= col_tgt_in;
         col_base_ff <= col_base_in;
         row_tgt_ff  <= row_tgt_in;
         row_base_ff <= row_base_in;
      end
   end

   assign pos.hit    = hit;
   assign pos.dest_x = nds_pkg::COORD_W'(cur_dst_col);
   assign pos.dest_y = nds_pkg::COORD_W'(cur_dst_row);
   assign pos.last   = (({1'b0, cur_dst_col} + (WS_W+1)'(1)) == {1'b0, dst_width}) &&
                       (({1'b0, cur_dst_row} + (HS_W+1)'(1)) == {1'b0, dst_height});

endmodule

`default_nettype wire

FILE: design/nds_pixel_pipe.sv
// Two-stage pixel pipeline: RGB565 expansion, then luma and result register.
// Depends on nds_pkg.
`default_nettype none

module nds_pixel_pipe (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire logic [15:0]             pixel,
   input  wire nds_pkg::pos_type        pos,
   input  wire logic                    gray_mode,
   input  wire logic                    rsp_stall,
   output logic                         rsp_valid,
   output nds_pkg::rsp_type             rsp_data,
   output nds_pkg::pipe_status_type     status
);

   logic                        s1_valid_ff, s1_valid_in;
   logic [7:0]                  s1_red_ff, s1_green_ff, s1_blue_ff;
   logic                        s1_gray_ff;
   logic [nds_pkg::COORD_W-1:0] s1_x_ff, s1_y_ff;
   logic                        s1_last_ff;
   logic                        rsp_valid_ff;
   nds_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   logic                        s2_adv, s1_adv;
   logic [15:0]                 luma_sum;

   assign s2_adv      = !rsp_valid_ff || !rsp_stall;
   assign s1_adv      = !s1_valid_ff || s2_adv;
   assign s1_valid_in = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && load) begin
         s1_red_ff   <= nds_pkg::expand5(pixel[15:11]);
         s1_green_ff <= nds_pkg::expand6(pixel[10:5]);
         s1_blue_ff  <= nds_pkg::expand5(pixel[4:0]);
         s1_gray_ff  <= gray_mode;
         s1_x_ff     <= pos.dest_x;
         s1_y_ff     <= pos.dest_y;
         s1_last_ff  <= pos.last;
      end
   end

   assign luma_sum = 16'(s1_red_ff) * 16'd77 + 16'(s1_green_ff) * 16'd150 +
                     16'(s1_blue_ff) * 16'd29;

   always_comb begin
      rsp_data_in.red           = s1_red_ff;
      rsp_data_in.green         = s1_green_ff;
      rsp_data_in.blue          = s1_blue_ff;
      rsp_data_in.luma          = s1_gray_ff ? luma_sum[15:8] : 8'd0;
      rsp_data_in.dest_x        = s1_x_ff;
      rsp_data_in.dest_y        = s1_y_ff;
      rsp_data_in.last_of_frame = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.s1_valid = s1_valid_ff;
   assign status.s1_ready = s1_adv;

endmodule

`default_nettype wire

FILE: design/nearest_downscale_rgb565.sv
// Top level of the nearest-neighbor RGB565 downscaler: registers, size clamp,
// position tracker and pixel pipeline. Depends on nds_pkg, nds_position, nds_pixel_pipe.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   request | req_valid, req_stall, req_data | in
//   result  | rsp_valid, rsp_stall, rsp_data | out
//   csr     | csr_write, csr_index, csr_wdata| in
//
// One request per cycle while req_stall is low; a selected pixel is registered in the
// expansion stage at the accepting edge, then in the luma/result register, before rsp.
// Position counters update in the accepting cycle; other requests give no result.
// req_stall rises only while both pipeline stages are full and rsp is stalled.
// Synchronous reset clears counters, valid bits and config registers to their defaults.
`default_nettype none

module nearest_downscale_rgb565 #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire nds_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output nds_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_write,
   input  wire logic [nds_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [nds_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int WS_W = $clog2(MAX_WIDTH + 1);
   localparam int HS_W = $clog2(MAX_HEIGHT + 1);

   logic [nds_pkg::CSR_DATA_W-1:0] src_width_ff, src_height_ff;
   logic [nds_pkg::CSR_DATA_W-1:0] dst_width_ff, dst_height_ff;
   logic                           gray_mode_ff;

   logic [WS_W-1:0] sw, dw;
   logic [HS_W-1:0] sh, dh;
   logic            accept;

   nds_pkg::pos_type         pos;
   nds_pkg::pipe_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 12'd320;
         src_height_ff <= 12'd240;
         dst_width_ff  <= 12'd96;
         dst_height_ff <= 12'd96;
         gray_mode_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            nds_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            nds_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            nds_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata;
            nds_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_wdata;
            nds_pkg::CSR_GRAY_MODE:  gray_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // size clamp: source to [1, MAX], destination to [1, source]
   always_comb begin
      if (src_width_ff == '0) sw = WS_W'(1);
      else if (32'(src_width_ff) > 32'(MAX_WIDTH)) sw = WS_W'(MAX_WIDTH);
      else sw = WS_W'(src_width_ff);
      if (src_height_ff == '0) sh = HS_W'(1);
      else if (32'(src_height_ff) > 32'(MAX_HEIGHT)) sh = HS_W'(MAX_HEIGHT);
      else sh = HS_W'(src_height_ff);
      if (dst_width_ff == '0) dw = WS_W'(1);
      else if (32'(dst_width_ff) > 32'(sw)) dw = sw;
      else dw = WS_W'(dst_width_ff);
      if (dst_height_ff == '0) dh = HS_W'(1);
      else if (32'(dst_height_ff) > 32'(sh)) dh = sh;
      else dh = HS_W'(dst_height_ff);
   end

   assign req_stall = !status.s1_ready;
   assign accept    = req_valid && !req_stall;

   nds_position #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_position (
      .clock          (clock),
      .reset          (reset),
      .advance        (accept),
      .start_of_frame (req_data.start_of_frame),
      .src_width      (sw),
      .src_height     (sh),
      .dst_width      (dw),
      .dst_height     (dh),
      .pos            (pos)
   );

   nds_pixel_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .load      (accept && pos.hit),
      .pixel     (req_data.pixel),
      .pos       (pos),
      .gray_mode (gray_mode_ff),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .status    (status)
   );

`ifndef ASSERT_OFF
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (status.s1_valid && rsp_valid && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_hit_loads: assert property (@(posedge clock) disable iff (reset)
      (accept && pos.hit) |=> status.s1_valid)
      else $error("selected pixel not captured");

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(status.s1_valid))
      else $error("result without a filled first stage");
`endif

endmodule

`default_nettype wire

FILE: dv/nds_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for nearest_downscale_rgb565: follows the register writes, predicts
// which requests produce a pixel and compares every result. Depends on nds_pkg.
module nds_scoreboard #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  nds_pkg::req_type                     req_data,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  nds_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write,
   input  logic [nds_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [nds_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                   mismatches,
   output int                                   pending
);

   localparam int CW = nds_pkg::COORD_W;

   logic [nds_pkg::CSR_DATA_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
   logic                           gray_reg;

   logic [CW-1:0] src_col, src_row;
   logic [CW:0]   dst_col, dst_row;
   logic [22:0]   col_target, col_base, row_target, row_base;

   nds_pkg::rsp_type expected_pixels[$];

   function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic clear_position();
      src_col = '0;
      src_row = '0;
      dst_col = '0;
      dst_row = '0;
      col_target = '0;
      col_base = '0;
      row_target = '0;
      row_base = '0;
   endtask

   task automatic track_request(input nds_pkg::req_type rq);
      int unsigned sw, sh, dw, dh;
      int unsigned r5, g6, b5, r8, g8, b8;
      logic row_hit, col_hit;
      nds_pkg::rsp_type px;
      sw = fit_size(src_w_reg, MAX_WIDTH);
      sh = fit_size(src_h_reg, MAX_HEIGHT);
      dw = fit_size(dst_w_reg, sw);
      dh = fit_size(dst_h_reg, sh);
      if (rq.start_of_frame) clear_position();

      row_hit = (32'(dst_row) < dh) && (row_base <= row_target) &&
                (32'(row_target) < 32'(row_base) + dh);
      col_hit = (32'(dst_col) < dw) && (col_base <= col_target) &&
                (32'(col_target) < 32'(col_base) + dw);

      if (row_hit && col_hit) begin
         r5 = rq.pixel[15:11];
         g6 = rq.pixel[10:5];
         b5 = rq.pixel[4:0];
         r8 = (r5 * 255 + 15) / 31;
         g8 = (g6 * 255 + 31) / 63;
         b8 = (b5 * 255 + 15) / 31;
         px.red = 8'(r8);
         px.green = 8'(g8);
         px.blue = 8'(b8);
         px.luma = gray_reg ? 8'((77 * r8 + 150 * g8 + 29 * b8) >> 8) : 8'd0;
         px.dest_x = CW'(dst_col);
         px.dest_y = CW'(dst_row);
         px.last_of_frame = (32'(dst_col) + 1 == dw) && (32'(dst_row) + 1 == dh);
         expected_pixels.push_back(px);
         dst_col = dst_col + (CW+1)'(1);
         col_target = col_target + 23'(sw);
      end

      if (32'(src_col) + 1 >= sw) begin
         src_col = '0;
         col_base = '0;
         dst_col = '0;
         col_target = '0;
         if (32'(src_row) + 1 >= sh) begin
            clear_position();
         end else begin
            if (row_hit) begin
               dst_row = dst_row + (CW+1)'(1);
               row_target = row_target + 23'(sh);
            end
            src_row = src_row + CW'(1);
            row_base = row_base + 23'(dh);
         end
      end else begin
         src_col = src_col + CW'(1);
         col_base = col_base + 23'(dw);
      end
   endtask

   task automatic check_field(input string what, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v != got_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      nds_pkg::rsp_type want;
      if (reset) begin
         src_w_reg = 12'd320;
         src_h_reg = 12'd240;
         dst_w_reg = 12'd96;
         dst_h_reg = 12'd96;
         gray_reg = 1'b0;
         clear_position();
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: result expected none actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("red", want.red, rsp_data.red);
               check_field("green", want.green, rsp_data.green);
               check_field("blue", want.blue, rsp_data.blue);
               check_field("luma", want.luma, rsp_data.luma);
               check_field("dest_x", want.dest_x, rsp_data.dest_x);
               check_field("dest_y", want.dest_y, rsp_data.dest_y);
               check_field("last_of_frame", want.last_of_frame, rsp_data.last_of_frame);
            end
         end
         if (csr_write) begin
            case (csr_index)
               nds_pkg::CSR_SRC_WIDTH: src_w_reg = csr_wdata;
               nds_pkg::CSR_SRC_HEIGHT: src_h_reg = csr_wdata;
               nds_pkg::CSR_DST_WIDTH: dst_w_reg = csr_wdata;
               nds_pkg::CSR_DST_HEIGHT: dst_h_reg = csr_wdata;
               nds_pkg::CSR_GRAY_MODE: gray_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) track_request(req_data);
      end
      pending = expected_pixels.size();
   end

endmodule

FILE: dv/nearest_downscale_rgb565_test.sv
`timescale 1ns / 100ps
// Testbench top for nearest_downscale_rgb565: clock, reset, register setup and
// request traffic with random idling. Depends on nds_pkg, the block and nds_scoreboard.
module nearest_downscale_rgb565_test;

   localparam int MAX_WIDTH     = 2048;
   localparam int MAX_HEIGHT    = 2048;
   localparam int RANDOM_ITEMS  = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 1000000;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   nds_pkg::req_type                   req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b1;
   nds_pkg::rsp_type                   rsp_data;
   logic                               csr_write = 1'b0;
   logic [nds_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [nds_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   int          mismatches;
   int          pending;
   int          cycle_count = 0;
   int          random_sent = 0;
   int unsigned stall_left = 0;
   bit          steady_sender = 1'b0;
   bit          steady_receiver = 1'b0;

   logic [15:0] corner_pixels[8] = '{16'hFFFF, 16'h0000, 16'hF800, 16'h07E0,
                                     16'h001F, 16'h0821, 16'h8410, 16'h7BEF};

   nearest_downscale_rgb565 #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   nds_scoreboard #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) scoreboard (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .mismatches(mismatches),
      .pending   (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: after each taken result, stall for a drawn number of cycles unless steady
   always @(posedge clock) begin
      int unsigned n;
      if (reset) begin
         rsp_stall <= 1'b1;
         stall_left <= 0;
      end else if (rsp_stall) begin
         if (stall_left == 0) rsp_stall <= 1'b0;
         else stall_left <= stall_left - 1;
      end else if (rsp_valid) begin
         if ($urandom_range(0, 49) == 0) steady_receiver <= !steady_receiver;
         n = steady_receiver ? 0 : $urandom_range(0, 10);
         if (n != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= n - 1;
         end
      end
   end

   task automatic send_pixel(input logic [15:0] pix, input logic sof);
      int unsigned gap;
      gap = steady_sender ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{pixel: pix, start_of_frame: sof};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_frame(input int unsigned count, input bit with_sof);
      for (int i = 0; i < count; i++) send_pixel(16'($urandom), with_sof && i == 0);
   endtask

   // drain all results, then give the pipeline time for requests with no result
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [nds_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [nds_pkg::CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_setting(input int unsigned sw, input int unsigned sh,
                               input int unsigned dw, input int unsigned dh,
                               input int unsigned gray_word);
      settle();
      write_csr(nds_pkg::CSR_SRC_WIDTH, 12'(sw));
      write_csr(nds_pkg::CSR_SRC_HEIGHT, 12'(sh));
      write_csr(nds_pkg::CSR_DST_WIDTH, 12'(dw));
      write_csr(nds_pkg::CSR_DST_HEIGHT, 12'(dh));
      write_csr(nds_pkg::CSR_GRAY_MODE, 12'(gray_word));
      // unmapped indexes must be ignored
      if ($urandom_range(0, 3) == 0)
         write_csr(3'(nds_pkg::CSR_GRAY_MODE + $urandom_range(1, 3)), 12'($urandom));
      csr_write <= 1'b0;
   endtask

   initial begin
      int unsigned sw, sh, n, kind;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: 320x240 down to 96x96
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i], i == 0);

      // every source pixel kept, gray on
      load_setting(4, 2, 4, 2, 12'hFFF);
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i], i == 0);
      // next frame starts without a marker
      repeat (3) send_pixel(16'($urandom), 1'b0);
      // sizes change mid-frame
      load_setting(4, 2, 2, 0, 12'h001);
      repeat (5) send_pixel(16'($urandom), 1'b0);

      // widest and tallest sizes, clamped, partial frames
      load_setting(2048, 1, 2048, 1, 12'h001);
      send_frame(200, 1'b1);
      load_setting(1, 2048, 4095, 2048, 12'h000);
      send_frame(200, 1'b1);
      load_setting(4095, 4095, 0, 0, 12'h001);
      send_frame(40, 1'b1);
      load_setting(0, 0, 0, 0, 12'h001);
      send_frame(20, 1'b0);

      while (random_sent < RANDOM_ITEMS) begin
         sw = $urandom_range(0, 16);
         sh = $urandom_range(0, 8);
         load_setting(sw, sh, $urandom_range(0, sw + 3), $urandom_range(0, sh + 3),
                      $urandom_range(0, 4095));
         steady_sender = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) begin
            kind = $urandom_range(0, 9);
            n = (sw == 0 ? 1 : sw) * (sh == 0 ? 1 : sh);
            if (kind < 7) begin
               send_frame(n, kind != 0);
            end else if (kind == 7) begin
               n = $urandom_range(1, n);
               send_frame(n, 1'b1);
            end else begin
               n = $urandom_range(1, 24);
               repeat (n) send_pixel(16'($urandom), $urandom_range(0, 7) == 0);
            end
            random_sent += n;
         end
      end

      settle();
      if (mismatches == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
